@@ sv/u8sd_pkg.sv @@
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned CntW  = 3;
  localparam int unsigned OutDW = 24;

  localparam logic [CpW-1:0] ReplChar = 21'h00003F;

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_kind_t;

  // Results of one accepted byte: cnt items, all '?' but the last, which is cp.
  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic [CpW-1:0]  cp;
    logic            eos;
  } burst_t;

  function automatic lead_kind_t lead_kind(input logic [7:0] b);
    lead_kind_t k;
    if (b[7] == 1'b0) begin
      k = LEAD_ASCII;
    end else if (b[7:5] == 3'b110) begin
      k = LEAD_TWO;
    end else if (b[7:4] == 4'b1110) begin
      k = LEAD_THREE;
    end else if (b[7:3] == 5'b11110) begin
      k = LEAD_FOUR;
    end else begin
      k = LEAD_BAD;
    end
    return k;
  endfunction

endpackage

@@ sv/u8sd_decode.sv @@
// ----------------------------------------------------------------------------
// u8sd_decode
// Sequence state and combinational decode of one byte into a result burst.
// ----------------------------------------------------------------------------
module u8sd_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_string,
  output u8sd_pkg::burst_t      burst
);

  logic [u8sd_pkg::CpW-1:0] pv_r, pv_nxt;
  logic [1:0]               need_r, need_nxt;
  logic [1:0]               held_r, held_nxt;

  logic                     pending;
  logic                     is_cont;
  logic [u8sd_pkg::CpW-1:0] pv_cont;
  logic [1:0]               need_dec;
  logic [1:0]               held_inc;
  logic [u8sd_pkg::CntW-1:0] flush_cnt;
  u8sd_pkg::lead_kind_t     kind;

  always_comb begin
    pending   = (need_r != 2'd0);
    is_cont   = (data_byte[7:6] == 2'b10);
    pv_cont   = {pv_r[u8sd_pkg::CpW-7:0], data_byte[5:0]};
    need_dec  = need_r - 2'd1;
    held_inc  = held_r + 2'd1;
    flush_cnt = pending ? (3'd1 + {1'b0, held_r}) : 3'd0;
    kind      = u8sd_pkg::lead_kind(data_byte);

    pv_nxt    = '0;
    need_nxt  = 2'd0;
    held_nxt  = 2'd0;
    burst.cnt = '0;
    burst.cp  = u8sd_pkg::ReplChar;
    burst.eos = end_of_string;

    if (pending && is_cont) begin
      if (need_dec == 2'd0) begin
        burst.cnt = 3'd1;
        burst.cp  = pv_cont;
      end else if (end_of_string) begin
        burst.cnt = 3'd1 + {1'b0, held_inc};
      end else begin
        pv_nxt   = pv_cont;
        need_nxt = need_dec;
        held_nxt = held_inc;
      end
    end else begin
      case (kind)
        u8sd_pkg::LEAD_ASCII: begin
          burst.cnt = flush_cnt + 3'd1;
          burst.cp  = {13'd0, data_byte};
        end
        u8sd_pkg::LEAD_TWO, u8sd_pkg::LEAD_THREE, u8sd_pkg::LEAD_FOUR: begin
          if (end_of_string) begin
            burst.cnt = flush_cnt + 3'd1;
          end else begin
            burst.cnt = flush_cnt;
            if (kind == u8sd_pkg::LEAD_TWO) begin
              pv_nxt   = {16'd0, data_byte[4:0]};
              need_nxt = 2'd1;
            end else if (kind == u8sd_pkg::LEAD_THREE) begin
              pv_nxt   = {17'd0, data_byte[3:0]};
              need_nxt = 2'd2;
            end else begin
              pv_nxt   = {18'd0, data_byte[2:0]};
              need_nxt = 2'd3;
            end
          end
        end
        default: begin
          burst.cnt = flush_cnt + 3'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= '0;
      need_r <= 2'd0;
      held_r <= 2'd0;
    end else if (accept) begin
      pv_r   <= pv_nxt;
      need_r <= need_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

@@ sv/u8sd_emit.sv @@
// ----------------------------------------------------------------------------
// u8sd_emit
// Result register: holds one burst and plays it out one item per handshake.
// ----------------------------------------------------------------------------
module u8sd_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  u8sd_pkg::burst_t              burst,
  output logic                          can_load,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [u8sd_pkg::CpW-1:0]      out_cp,
  output logic                          out_final
);

  logic [u8sd_pkg::CntW-1:0] rem_r, rem_nxt;
  logic [u8sd_pkg::CpW-1:0]  cp_r, cp_nxt;
  logic                      eos_r, eos_nxt;
  logic                      fire;
  logic                      take;

  always_comb begin
    out_valid = (rem_r != 3'd0);
    fire      = out_valid && out_ready;
    can_load  = (rem_r == 3'd0) || ((rem_r == 3'd1) && out_ready);
    take      = load && (burst.cnt != 3'd0);
    out_cp    = (rem_r == 3'd1) ? cp_r : u8sd_pkg::ReplChar;
    out_final = eos_r && (rem_r == 3'd1);

    rem_nxt = fire ? (rem_r - 3'd1) : rem_r;
    cp_nxt  = cp_r;
    eos_nxt = eos_r;
    if (take) begin
      rem_nxt = burst.cnt;
      cp_nxt  = burst.cp;
      eos_nxt = burst.eos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r  <= cp_nxt;
    eos_r <= eos_nxt;
  end

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 3'd4)
    else $error("burst count out of range");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> (rem_r == 3'd0) || ((rem_r == 3'd1) && out_ready))
    else $error("burst loaded over pending items");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && rem_r > 3'd1) |=> rem_r == $past(rem_r) - 3'd1)
    else $error("burst count did not advance");

  a_repl_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && rem_r != 3'd1) |-> (out_cp == u8sd_pkg::ReplChar && !out_final))
    else $error("non-final item of a burst is not a replacement");

endmodule

@@ sv/utf8_stream_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Lenient streaming UTF-8 decoder: bytes in, code points out.
// ----------------------------------------------------------------------------
// Input channel in_*: one byte per item in in_tdata, in_tlast marks the last
// byte of a string. Output channel out_*: one code point per item in
// out_tdata[20:0], out_tlast set on the last result of a string.
// A byte is decoded in the cycle it is accepted and its results appear in
// the result register on the next cycle. A byte gives zero to four results;
// the result register plays them out one per cycle while out_tready is high,
// so the input then takes one byte per cycle whenever each byte gives at most
// one result, and a byte giving more holds the input until its last is taken.
// Bytes that only extend a pending sequence give nothing and pass at once.
// A new byte is taken in the cycle the last pending result is taken.
// Reset clears the sequence state and drops any results not yet taken.
// When the receiver stalls, results hold in the register and in_tready
// stays low while any result waits untaken, the one being offered included.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] data_byte
  input  logic                      in_tlast,   // end_of_string
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [u8sd_pkg::OutDW-1:0] out_tdata, // [20:0] code_point, zero above
  output logic                      out_tlast   // final_result
);

  u8sd_pkg::burst_t          burst;
  logic                      can_load;
  logic                      accept;
  logic [u8sd_pkg::CpW-1:0]  cp;

  assign in_tready = can_load;
  assign accept    = in_tvalid && can_load;
  assign out_tdata = {{(u8sd_pkg::OutDW - u8sd_pkg::CpW){1'b0}}, cp};

  u8sd_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_tdata),
    .end_of_string (in_tlast),
    .burst         (burst)
  );

  u8sd_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .burst     (burst),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_cp    (cp),
    .out_final (out_tlast)
  );

endmodule

@@ dv/utf8_stream_decoder_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit_tb
// Self-checking bench for the lenient UTF-8 stream decoder. A directed set of
// byte strings hits the lead classes, the largest four-byte value, stray and bad
// leads, broken and cut-off sequences; random strings follow, mostly
// well-formed, the rest broken or noise. A local decoder predicts every code
// point and its end-of-string flag; both sides idle at random but in a calm window.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit_tb;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
  } byte_item_t;

  typedef struct packed {
    logic [u8sd_pkg::CpW-1:0] cp;
    logic                     last;
  } cp_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] data_byte
  logic in_tlast = 1'b0;          // end_of_string
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [u8sd_pkg::OutDW-1:0] out_tdata;    // [20:0] code_point, zero above
  logic out_tlast;                // final_result

  utf8_stream_decoder_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  byte_item_t pending_bytes[$];
  cp_item_t   expected_cps[$];
  cp_item_t   step_cps[$];
  byte_item_t cur_byte;

  logic [u8sd_pkg::CpW-1:0] acc_cp = '0;
  logic [1:0]     cont_left = '0;
  logic [1:0]     cont_held = '0;

  int n_queued = 0;
  int n_accepted = 0;
  int n_strings = 0;
  int n_checked = 0;
  int n_errors = 0;

  function automatic bit calm_window();
    return (n_accepted >= 80) && (n_accepted < 130);
  endfunction

  task automatic emit_cp(input logic [u8sd_pkg::CpW-1:0] cp);
    cp_item_t r;
    r.cp   = cp;
    r.last = 1'b0;
    if (step_cps.size() < 4) step_cps.insert(step_cps.size(), r);
  endtask

  task automatic flush_seq();
    int k;
    for (k = 0; k <= int'(cont_held); k++) emit_cp(u8sd_pkg::ReplChar);
    acc_cp    = '0;
    cont_left = '0;
    cont_held = '0;
  endtask

  task automatic start_seq(input logic [7:0] b);
    casez (b)
      8'b0???????: emit_cp({13'd0, b});
      8'b110?????: begin
        acc_cp    = {16'd0, b[4:0]};
        cont_left = 2'd1;
        cont_held = 2'd0;
      end
      8'b1110????: begin
        acc_cp    = {17'd0, b[3:0]};
        cont_left = 2'd2;
        cont_held = 2'd0;
      end
      8'b11110???: begin
        acc_cp    = {18'd0, b[2:0]};
        cont_left = 2'd3;
        cont_held = 2'd0;
      end
      default: emit_cp(u8sd_pkg::ReplChar);
    endcase
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eos);
    cp_item_t r;
    step_cps.delete();
    if (cont_left != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        acc_cp    = {acc_cp[u8sd_pkg::CpW-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        cont_held = cont_held + 2'd1;
        if (cont_left == 2'd0) begin
          emit_cp(acc_cp);
          acc_cp    = '0;
          cont_held = '0;
        end
      end else begin
        flush_seq();
        start_seq(b);
      end
    end else begin
      start_seq(b);
    end
    if (eos) begin
      n_strings++;
      if (cont_left != 2'd0) flush_seq();
      if (step_cps.size() > 0) step_cps[step_cps.size()-1].last = 1'b1;
    end
    while (step_cps.size() > 0) begin
      r = step_cps.pop_front();
      expected_cps.insert(expected_cps.size(), r);
    end
  endtask

  // Driver: hold the item until accepted, then advance or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_byte(cur_byte.b, cur_byte.eos);
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_bytes.size() > 0 && (calm_window() || $urandom_range(0, 99) >= 28)) begin
          cur_byte = pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= cur_byte.b;
          in_tlast  <= cur_byte.eos;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction.
  always @(posedge clk) begin
    cp_item_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_cps.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected result: tdata %h last %b", out_tdata, out_tlast);
      end else begin
        e = expected_cps.pop_front();
        n_checked++;
        if (out_tdata !== {{(u8sd_pkg::OutDW-u8sd_pkg::CpW){1'b0}}, e.cp} ||
            out_tlast !== e.last) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: expected cp %h last %b, got tdata %h last %b",
                     e.cp, e.last, out_tdata, out_tlast);
        end
      end
    end
    out_tready <= calm_window() || ($urandom_range(0, 99) >= 28);
  end

  task automatic push_byte(input logic [7:0] b, input logic eos);
    byte_item_t it;
    it.b   = b;
    it.eos = eos;
    pending_bytes.insert(pending_bytes.size(), it);
    n_queued++;
  endtask

  function automatic logic [7:0] lead_for(input int len);
    logic [7:0] r;
    r = 8'($urandom);
    case (len)
      1:       r = {1'b0, r[6:0]};
      2:       r = {3'b110, r[4:0]};
      3:       r = {4'b1110, r[3:0]};
      default: r = {5'b11110, r[2:0]};
    endcase
    return r;
  endfunction

  initial begin
    int len;
    int held;
    int k;
    bit cut;
    bit eos_mark;
    logic [7:0] b;

    // Directed strings.
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b1);
    push_byte(8'hC2, 1'b0);
    push_byte(8'hA9, 1'b0);
    push_byte(8'hE2, 1'b0);
    push_byte(8'h82, 1'b0);
    push_byte(8'hAC, 1'b1);
    push_byte(8'hF7, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hF8, 1'b1);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h90, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'hE2, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'hA9, 1'b1);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h90, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'hC3, 1'b0);
    push_byte(8'hE2, 1'b1);

    // Random strings: mostly well-formed, some broken, some noise.
    while (n_queued < 180) begin
      eos_mark = ($urandom_range(0, 7) == 0);
      k = $urandom_range(0, 99);
      if (k < 70) begin
        len = $urandom_range(1, 4);
        push_byte(lead_for(len), eos_mark && len == 1);
        for (held = 1; held < len; held++)
          push_byte({2'b10, 6'($urandom)}, eos_mark && held == len - 1);
      end else if (k < 85) begin
        len  = $urandom_range(2, 4);
        held = $urandom_range(0, len - 2);
        cut  = ($urandom_range(0, 2) == 0);
        push_byte(lead_for(len), cut && held == 0);
        for (k = 0; k < held; k++)
          push_byte({2'b10, 6'($urandom)}, cut && k == held - 1);
        if (!cut) begin
          b = 8'($urandom);
          if (b[7:6] == 2'b10) b[6] = 1'b1;
          push_byte(b, eos_mark);
        end
      end else begin
        push_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_cps.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d bytes in %0d strings, %0d code points checked",
             n_accepted, n_strings, n_checked);
    if (n_errors == 0 && expected_cps.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d errors, %0d results missing", n_errors, expected_cps.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/u8sd_pkg.sv
sv/u8sd_decode.sv
sv/u8sd_emit.sv
sv/utf8_stream_decoder_unit.sv
dv/utf8_stream_decoder_unit_tb.sv
